// File: rtl/gcol_pkg.sv
// Shared constants and types for the greedy graph coloring block.
// No dependencies; the lane, merge and top-level files use names from here.
package gcol_pkg;

   // Largest graph the block can hold.
   localparam int MAX_VERTICES = 32;

   // Width of one adjacency row on the request channel.
   localparam int ROW_W = 32;

   // Lanes: one per vertex that a row can reach.
   localparam int LANES = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;

   // Field widths.
   localparam int IDX_W   = 5;
   localparam int COLOR_W = 6;

   // Vertex count after reset.
   localparam logic [COLOR_W-1:0] COUNT_RESET = COLOR_W'(LANES);

   typedef logic [IDX_W-1:0]   index_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [ROW_W-1:0]   row_type;

   // Bit k set: color k is taken by a neighbor. Bit 0 never set.
   typedef logic [LANES:0]     mask_type;

endpackage

// File: rtl/gcol_lane.sv
// One neighbor lane: decodes a stored color into a one-hot used-color mask.
// Depends on gcol_pkg.
module gcol_lane (
   input  logic                hit,
   input  gcol_pkg::color_type color,
   output gcol_pkg::mask_type  mask
);

   always_comb begin
      mask = '0;
      for (int k = 1; k <= gcol_pkg::LANES; k++) begin
         mask[k] = hit && (color == gcol_pkg::COLOR_W'(k));
      end
   end

endmodule

// File: rtl/gcol_merge.sv
// Merge stage: ORs the lane masks into a registered used-color set, then
// picks the lowest free color up to the vertex count. Depends on gcol_pkg.
module gcol_merge (
   input  logic                clock,
   input  logic                load,
   input  gcol_pkg::mask_type  lane_mask [gcol_pkg::LANES],
   input  gcol_pkg::color_type count,
   output gcol_pkg::color_type color
);

   gcol_pkg::mask_type used_ff;
   gcol_pkg::mask_type used_in;
   gcol_pkg::mask_type free_set;

   always_comb begin
      used_in = '0;
      for (int j = 0; j < gcol_pkg::LANES; j++) begin
         used_in = used_in | lane_mask[j];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         used_ff <= used_in;
      end
   end

   // Lowest free color in 1..count; 0 when all are taken.
   always_comb begin
      free_set = '0;
      color    = '0;
      for (int k = 1; k <= gcol_pkg::LANES; k++) begin
         free_set[k] = !used_ff[k] && (gcol_pkg::COLOR_W'(k) <= count);
      end
      for (int k = gcol_pkg::LANES; k >= 1; k--) begin
         if (free_set[k]) begin
            color = gcol_pkg::COLOR_W'(k);
         end
      end
   end

endmodule

// File: rtl/greedy_graph_coloring.sv
// Top level of the greedy first-fit graph coloring block.
// Depends on gcol_pkg, gcol_lane and gcol_merge.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------
//   req      | in        | tvalid / tready    | tdata: row_bits
//   rsp      | out       | tvalid / tready    | tdata: vertex_index, vertex_color,
//            |           |                    |        max_color; tlast: graph_done
//   csr      | in        | write enable only  | wdata: vertex_count
//
// Each request is handled in order: the lanes decode and OR the neighbor colors
// into the merge register, then the lowest free color is picked and stored.
// A new request is taken only once the merge register has emptied, so the block
// does not take a new request until the last one has moved to the response register.
// Reset clears the vertex counter and running maximum and sets the vertex
// count to 32; the color store holds no reset value. A stalled response
// holds the merge register, which in turn holds off req_tready.
module greedy_graph_coloring (
   input  logic        clock,
   input  logic        reset,
   // request: row_bits [31:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: vertex_index [4:0], vertex_color [10:5], max_color [16:11], zero [23:17]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   // vertex_count register
   input  logic        csr_write_en,
   input  logic [5:0]  csr_write_data
);

   localparam int LANES   = gcol_pkg::LANES;
   localparam int COLOR_W = gcol_pkg::COLOR_W;
   localparam int IDX_W   = gcol_pkg::IDX_W;

   // Configuration and graph progress.
   gcol_pkg::color_type count_ff,    count_in;
   gcol_pkg::index_type row_cnt_ff,  row_cnt_in;
   gcol_pkg::color_type run_max_ff,  run_max_in;

   // Color of every vertex colored so far in this graph.
   gcol_pkg::color_type store_ff [LANES];

   // Merge stage holds one request.
   logic                mrg_valid_ff, mrg_valid_in;
   gcol_pkg::index_type mrg_index_ff;

   // Response register.
   logic                out_valid_ff, out_valid_in;
   gcol_pkg::index_type out_index_ff;
   gcol_pkg::color_type out_color_ff;
   gcol_pkg::color_type out_max_ff;
   logic                out_last_ff;

   logic                accept;
   logic                advance;
   gcol_pkg::mask_type  lane_mask [LANES];
   gcol_pkg::color_type pick_color;
   gcol_pkg::color_type reached;
   gcol_pkg::color_type prev_max;
   gcol_pkg::color_type new_max;
   logic                last_vertex;
   gcol_pkg::color_type wr_count;

   assign req_tready = !mrg_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign advance    = mrg_valid_ff && (!out_valid_ff || rsp_tready);

   // One lane per earlier vertex. Vertex 0 counts as color 1 on its own row,
   // so its self-loop blocks color 1; other self-loops fall outside j < i.
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic                hit;
      gcol_pkg::color_type lane_color;

      if (j == 0) begin : g_first
         assign hit        = req_tdata[0];
         assign lane_color = (row_cnt_ff == '0) ? COLOR_W'(1) : store_ff[0];
      end else begin : g_rest
         assign hit        = req_tdata[j] && (IDX_W'(j) < row_cnt_ff);
         assign lane_color = store_ff[j];
      end

      gcol_lane u_lane (
         .hit   (hit),
         .color (lane_color),
         .mask  (lane_mask[j])
      );
   end

   gcol_merge u_merge (
      .clock     (clock),
      .load      (accept),
      .lane_mask (lane_mask),
      .count     (count_ff),
      .color     (pick_color)
   );

   // Running maximum: no free color pushes it to count + 1.
   always_comb begin
      reached     = (pick_color != '0) ? pick_color : count_ff + COLOR_W'(1);
      prev_max    = (mrg_index_ff == '0) ? '0 : run_max_ff;
      new_max     = (reached > prev_max) ? reached : prev_max;
      last_vertex = (COLOR_W'(mrg_index_ff) + COLOR_W'(1)) >= count_ff;
   end

   // Clamp a written vertex count into 1..LANES.
   always_comb begin
      if (csr_write_data == '0) begin
         wr_count = COLOR_W'(1);
      end else if (csr_write_data > COLOR_W'(LANES)) begin
         wr_count = COLOR_W'(LANES);
      end else begin
         wr_count = csr_write_data;
      end
   end

   always_comb begin
      count_in     = count_ff;
      row_cnt_in   = row_cnt_ff;
      run_max_in   = run_max_ff;
      mrg_valid_in = mrg_valid_ff;
      out_valid_in = out_valid_ff;

      // Drop the response once it is taken.
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      // Advance the counter at accept so the index travels with the request.
      if (accept) begin
         mrg_valid_in = 1'b1;
         if ((COLOR_W'(row_cnt_ff) + COLOR_W'(1)) >= count_ff) begin
            row_cnt_in = '0;
         end else begin
            row_cnt_in = row_cnt_ff + IDX_W'(1);
         end
      end

      if (advance) begin
         mrg_valid_in = 1'b0;
         out_valid_in = 1'b1;
         run_max_in   = last_vertex ? '0 : new_max;
      end

      // A count write restarts the graph; the user must write it only while idle, as the block does not enforce this.
      if (csr_write_en) begin
         count_in   = wr_count;
         row_cnt_in = '0;
         run_max_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= gcol_pkg::COUNT_RESET;
         row_cnt_ff   <= '0;
         run_max_ff   <= '0;
         mrg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         row_cnt_ff   <= row_cnt_in;
         run_max_ff   <= run_max_in;
         mrg_valid_ff <= mrg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         mrg_index_ff <= row_cnt_ff;
      end
      if (advance) begin
         store_ff[mrg_index_ff] <= pick_color;
         out_index_ff           <= mrg_index_ff;
         out_color_ff           <= pick_color;
         out_max_ff             <= new_max;
         out_last_ff            <= last_vertex;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_max_ff, out_color_ff, out_index_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// File: rtl/gcol_checker.sv
// Port-level checks for greedy_graph_coloring, attached by the bind below.
// Depends only on the top level's ports.
module gcol_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // One request in flight: ready drops after every accepted request.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while merge stage busy");

   // The running maximum covers the color just assigned.
   a_max_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:5] != 6'd0 |-> rsp_tdata[16:11] >= rsp_tdata[10:5])
      else $error("max_color below vertex_color");

   // No free color means the maximum went past the vertex count.
   a_no_color_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:5] == 6'd0 |-> rsp_tdata[16:11] >= 6'd2)
      else $error("uncolored vertex without overflowed maximum");

   // Nothing comes out right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind greedy_graph_coloring gcol_assertions u_gcol_assertions (.*);
